>>> rtl/lmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_pkg
// Shared types and constants of the lineage mark filter.
// ----------------------------------------------------------------------------
package lmf_pkg;

  localparam int NODE_W = 16;
  localparam int NODES = 65536;
  localparam int IDX_W = $clog2(NODES);
  localparam int DEFAULT_MAX_DEPTH = 64;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_ENABLED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT = 2'd2;

  localparam logic [NODE_W-1:0] ROOT_NODE = 16'd1;
  localparam logic [NODE_W-1:0] NODE_LIMIT_RESET = 16'hFFFF;

  typedef logic signed [1:0] verdict_t;

  localparam verdict_t VERDICT_NONE = 2'sb00;
  localparam verdict_t VERDICT_INCLUDED = 2'sb01;
  localparam verdict_t VERDICT_EXCLUDED = 2'sb11;
  localparam verdict_t STATUS_OUT_OF_RANGE = 2'sb10;

  typedef enum logic [2:0] {
    OP_WRITE_PARENT  = 3'd0,
    OP_MARK_INCLUDE  = 3'd1,
    OP_MARK_EXCLUDE  = 3'd2,
    OP_QUERY_INCLUDE = 3'd3,
    OP_QUERY_EXCLUDE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/lmf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_in_if / lmf_out_if
// Valid/ready channels for requests and results of the lineage mark filter.
// ----------------------------------------------------------------------------
interface lmf_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          operation;
  logic [15:0]         node;
  logic [15:0]         parent_value;
  logic                parent_valid;
  logic signed [1:0]   initial_status;

  modport source (output valid, operation, node, parent_value, parent_valid,
                  initial_status, input ready);
  modport sink (input valid, operation, node, parent_value, parent_valid,
                initial_status, output ready);
endinterface

interface lmf_out_if;
  logic                valid;
  logic                ready;
  logic signed [1:0]   verdict;
  logic                mark_rejected;
  logic                depth_exceeded;

  modport source (output valid, verdict, mark_rejected, depth_exceeded,
                  input ready);
  modport sink (input valid, verdict, mark_rejected, depth_exceeded,
                output ready);
endinterface
`default_nettype wire

>>> rtl/lineage_mark_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lineage_mark_filter
// Parent table of tree nodes with include/exclude marks and ancestor queries.
// ----------------------------------------------------------------------------
// requests arrive on items (valid/ready), one result per request leaves on
// results through an output register, so a new request is taken while the
// previous result still waits for the receiver
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce
// parent links live in one single-port style memory, the two mark bits of
// each node in a second memory; both have registered reads
// steps per request, from acceptance to the result register:
//   parent write, unknown op, disabled query: straight to the done state
//   mark: read entry, then read-modify-write of the mark bits
//   query: L levels visited (1..MAX_DEPTH), one memory read
//   per level of the parent chain
// the next request can be taken in the cycle after the result is registered
// after reset the mark memory is cleared one entry a cycle, all NODES entries
// (65536), while items.ready stays low; configuration writes still apply
// a stalled receiver holds the finished result in the block until taken
// ----------------------------------------------------------------------------
module lineage_mark_filter
  import lmf_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lmf_in_if.sink                     items,
  lmf_out_if.source                  results
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(MAX_DEPTH - 1);

  // storage
  logic [NODE_W:0] parent_mem [NODES];
  logic [1:0]      mark_mem [NODES];
  logic [NODE_W:0] parent_q;
  logic [1:0]      mark_q;

  // configuration
  logic              include_enabled;
  logic              exclude_enabled;
  logic [NODE_W-1:0] node_limit;

  // control and request context
  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  clr_addr;
  op_t               op_q;
  logic [NODE_W-1:0] cur;
  logic [LVL_W-1:0]  level;
  verdict_t          init_q;

  verdict_t res_verdict;
  logic     res_rejected;
  logic     res_deep;

  logic     out_valid;
  verdict_t out_verdict;
  logic     out_rejected;
  logic     out_deep;

  // combinational controls
  logic              accept;
  op_t               in_op;
  logic              out_free;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              parent_we;
  logic              mark_we;
  logic [IDX_W-1:0]  mark_addr;
  logic [1:0]        mark_data;
  logic              res_load;
  verdict_t          res_verdict_next;
  logic              res_rejected_next;
  logic              res_deep_next;
  logic              walk_step;
  logic              walk_end;
  logic              mark_hit;
  verdict_t          hit_value;
  verdict_t          init_sat;

  assign in_op = op_t'(items.operation);
  assign accept = items.valid && items.ready;
  assign out_free = !out_valid || results.ready;
  assign init_sat = (items.initial_status == STATUS_OUT_OF_RANGE) ?
                    VERDICT_EXCLUDED : items.initial_status;
  assign mark_hit = (op_q == OP_QUERY_INCLUDE) ? mark_q[0] : mark_q[1];
  assign hit_value = (op_q == OP_QUERY_INCLUDE) ? VERDICT_INCLUDED : VERDICT_EXCLUDED;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {IDX_W{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (items.valid) begin
          case (in_op)
            OP_MARK_INCLUDE, OP_MARK_EXCLUDE: state_next = ST_MARK;
            OP_QUERY_INCLUDE: state_next = include_enabled ? ST_WALK : ST_DONE;
            OP_QUERY_EXCLUDE: state_next = exclude_enabled ? ST_WALK : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MARK: state_next = ST_DONE;
      ST_WALK: begin
        if (walk_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    items.ready       = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = items.node[IDX_W-1:0];
    parent_we         = 1'b0;
    mark_we           = 1'b0;
    mark_addr         = clr_addr;
    mark_data         = 2'b00;
    res_load          = 1'b0;
    res_verdict_next  = VERDICT_NONE;
    res_rejected_next = 1'b0;
    res_deep_next     = 1'b0;
    walk_step         = 1'b0;
    walk_end          = 1'b0;
    case (state)
      ST_CLEAR: begin
        mark_we = 1'b1;
      end
      ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          res_load = 1'b1;
          case (in_op)
            OP_WRITE_PARENT: parent_we = 1'b1;
            OP_MARK_INCLUDE, OP_MARK_EXCLUDE: rd_en = 1'b1;
            OP_QUERY_INCLUDE: begin
              rd_en = include_enabled;
              if (!include_enabled) res_verdict_next = VERDICT_INCLUDED;
            end
            OP_QUERY_EXCLUDE: begin
              rd_en = exclude_enabled;
              if (!exclude_enabled) res_verdict_next = VERDICT_INCLUDED;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_MARK: begin
        res_load = 1'b1;
        if (cur == '0 || cur > node_limit || !parent_q[NODE_W]) begin
          res_rejected_next = 1'b1;
        end else begin
          mark_we   = 1'b1;
          mark_addr = cur[IDX_W-1:0];
          mark_data = (op_q == OP_MARK_INCLUDE) ? (mark_q | 2'b01) : (mark_q | 2'b10);
        end
      end
      ST_WALK: begin
        walk_end = 1'b1;
        res_load = 1'b1;
        if (cur >= node_limit || !parent_q[NODE_W]) begin
          res_verdict_next = VERDICT_EXCLUDED;
        end else if (mark_hit) begin
          res_verdict_next = hit_value;
        end else if (parent_q[NODE_W-1:0] == ROOT_NODE) begin
          res_verdict_next = init_q;
        end else if (level == LAST_LEVEL) begin
          res_verdict_next = VERDICT_EXCLUDED;
          res_deep_next    = 1'b1;
        end else begin
          // follow the parent link one level up
          walk_end  = 1'b0;
          res_load  = 1'b0;
          walk_step = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = parent_q[IDX_W-1:0];
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (rd_en) begin
      parent_q <= parent_mem[rd_addr];
      mark_q   <= mark_mem[rd_addr];
    end
    if (parent_we) begin
      parent_mem[items.node[IDX_W-1:0]] <= {items.parent_valid, items.parent_value};
    end
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_data;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
      include_enabled <= 1'b0;
      exclude_enabled <= 1'b0;
      node_limit      <= NODE_LIMIT_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INCLUDE_ENABLED: include_enabled <= cfg_data[0];
          CFG_EXCLUDE_ENABLED: exclude_enabled <= cfg_data[0];
          CFG_NODE_LIMIT:      node_limit      <= cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // request context and results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= in_op;
      cur    <= items.node;
      level  <= '0;
      init_q <= init_sat;
    end else if (walk_step) begin
      cur   <= parent_q[NODE_W-1:0];
      level <= level + 1'b1;
    end
    if (res_load) begin
      res_verdict  <= res_verdict_next;
      res_rejected <= res_rejected_next;
      res_deep     <= res_deep_next;
    end
    if (state == ST_DONE && out_free) begin
      out_verdict  <= res_verdict;
      out_rejected <= res_rejected;
      out_deep     <= res_deep;
    end
  end

  assign results.valid          = out_valid;
  assign results.verdict        = out_verdict;
  assign results.mark_rejected  = out_rejected;
  assign results.depth_exceeded = out_deep;

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> level <= LAST_LEVEL)
    else $error("walk level beyond depth limit");

  a_deep_means_excluded: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.depth_exceeded |-> results.verdict == VERDICT_EXCLUDED)
    else $error("depth flag without excluded verdict");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.mark_rejected && results.depth_exceeded))
    else $error("mark and depth flags together");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !items.ready)
    else $error("second request taken while one is in progress");

endmodule
`default_nettype wire
